[rtl/fcc_pkg.sv]
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types, codes and the CRC-32 byte step of the frame chunker.
// ----------------------------------------------------------------------------
package fcc_pkg;

	localparam int IDX_W = 11;
	localparam int LEN_W = 24;
	localparam int DVD_W = 25;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
	localparam logic [15:0] PARITY_CHUNK = 16'hFFFF;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_DATA  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_PARITY = 2'd1;
	localparam logic [1:0] KIND_PBYTE  = 2'd2;
	localparam logic [1:0] KIND_STRAY  = 2'd3;

	typedef struct packed {
		logic accept;
		logic start;
		logic clr;
		logic apply;
		logic pad;
		logic hdr;
		logic rd_cnt;
		logic pstep;
		logic phdr;
		logic pbyte;
		logic stray;
	} ctrl_t;

	typedef struct packed {
		logic open;
		logic chunk_end;
		logic pad_done;
		logic frame_done;
		logic par_last;
		logic clr_last;
		logic slot_free;
	} sts_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

endpackage

[rtl/fcc_if.sv]
// ----------------------------------------------------------------------------
// fcc_if
// Request channels of the frame chunker: input requests and result requests.
// ----------------------------------------------------------------------------
interface fcc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] frame_seq;
	logic signed [63:0] frame_timestamp;
	logic [23:0] frame_length;
	logic [7:0]  data_byte;
	logic [10:0] parity_index;

	modport source(output valid, cmd, frame_seq, frame_timestamp, frame_length,
		data_byte, parity_index, input ready);
	modport sink(input valid, cmd, frame_seq, frame_timestamp, frame_length,
		data_byte, parity_index, output ready);
endinterface

interface fcc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [63:0] seq_out;
	logic signed [63:0] time_out;
	logic [15:0] chunk_idx;
	logic [15:0] chunk_total;
	logic [10:0] payload_length;
	logic [31:0] chunk_crc;
	logic [7:0]  parity_byte;
	logic        last;

	modport source(output valid, kind, seq_out, time_out, chunk_idx, chunk_total,
		payload_length, chunk_crc, parity_byte, last, input ready);
	modport sink(input valid, kind, seq_out, time_out, chunk_idx, chunk_total,
		payload_length, chunk_crc, parity_byte, last, output ready);
endinterface

[rtl/fcc_ctrl.sv]
// ----------------------------------------------------------------------------
// fcc_ctrl
// Controller state machine that sequences clearing, byte updates, padding,
// the parity pass and result requests.
// ----------------------------------------------------------------------------
module fcc_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [1:0]   in_cmd,
	output logic         in_ready,
	input  fcc_pkg::sts_t sts,
	output fcc_pkg::ctrl_t ctrl
);
	import fcc_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_CLEAR = 10'b00_0000_0010,
		S_APPLY = 10'b00_0000_0100,
		S_PAD   = 10'b00_0000_1000,
		S_HDR   = 10'b00_0001_0000,
		S_PRD   = 10'b00_0010_0000,
		S_PUPD  = 10'b00_0100_0000,
		S_PHDR  = 10'b00_1000_0000,
		S_PBYTE = 10'b01_0000_0000,
		S_STRAY = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.accept = 1'b1;
					case (in_cmd)
						CMD_START: begin
							ctrl.start = 1'b1;
							state_d = S_CLEAR;
						end
						CMD_DATA: begin
							state_d = sts.open ? S_APPLY : S_STRAY;
						end
						CMD_READ: begin
							state_d = S_PBYTE;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_CLEAR: begin
				ctrl.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_APPLY: begin
				ctrl.apply = 1'b1;
				state_d = sts.chunk_end ? S_PAD : S_IDLE;
			end
			S_PAD: begin
				if (sts.pad_done) begin
					state_d = S_HDR;
				end else begin
					ctrl.pad = 1'b1;
				end
			end
			S_HDR: begin
				if (sts.slot_free) begin
					ctrl.hdr = 1'b1;
					state_d = sts.frame_done ? S_PRD : S_IDLE;
				end
			end
			S_PRD: begin
				ctrl.rd_cnt = 1'b1;
				state_d = S_PUPD;
			end
			S_PUPD: begin
				ctrl.pstep = 1'b1;
				state_d = sts.par_last ? S_PHDR : S_PRD;
			end
			S_PHDR: begin
				if (sts.slot_free) begin
					ctrl.phdr = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_PBYTE: begin
				if (sts.slot_free) begin
					ctrl.pbyte = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_STRAY: begin
				if (sts.slot_free) begin
					ctrl.stray = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_IDLE))
		else $error("ready raised outside idle");
	a_hdr_after_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HDR) |-> sts.pad_done)
		else $error("header state entered before padding finished");
	a_pupd_follows_prd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUPD) |-> $past(state_q == S_PRD))
		else $error("parity update without a read");

endmodule

[rtl/fcc_datapath.sv]
// ----------------------------------------------------------------------------
// fcc_datapath
// Frame registers, parity memory, CRC register, chunk count multiplier and the
// result register of the frame chunker.
// ----------------------------------------------------------------------------
module fcc_datapath #(
	parameter int CHUNK_BYTES = 1100
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fcc_pkg::ctrl_t       ctrl,
	output fcc_pkg::sts_t        sts,
	input  logic [1:0]           in_cmd,
	input  logic [63:0]          in_seq,
	input  logic signed [63:0]   in_time,
	input  logic [23:0]          in_len,
	input  logic [7:0]           in_byte,
	input  logic [10:0]          in_idx,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           out_kind,
	output logic [63:0]          out_seq,
	output logic signed [63:0]   out_time,
	output logic [15:0]          out_index,
	output logic [15:0]          out_total,
	output logic [10:0]          out_len,
	output logic [31:0]          out_crc,
	output logic [7:0]           out_pbyte,
	output logic                 out_last
);
	import fcc_pkg::*;

	localparam int AW = $clog2(CHUNK_BYTES);
	localparam int RSH = DVD_W + AW;
	localparam int RCP_W = DVD_W + 1;
	localparam int PROD_W = DVD_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP =
		RCP_W'(((64'd1 << RSH) + 64'(CHUNK_BYTES - 1)) / 64'(CHUNK_BYTES));
	localparam logic [IDX_W-1:0] CHUNK_L = IDX_W'(CHUNK_BYTES);
	localparam logic [IDX_W-1:0] CHUNK_LAST = IDX_W'(CHUNK_BYTES - 1);
	localparam logic [DVD_W-1:0] ROUND_UP = DVD_W'(CHUNK_BYTES - 1);

	logic [7:0] mem [CHUNK_BYTES];
	logic [7:0] rdata_q;
	logic [AW-1:0] raddr, waddr;
	logic [7:0] wdata;
	logic we;

	logic [63:0] seq_q;
	logic signed [63:0] time_q;
	logic [LEN_W-1:0] left_q;
	logic [15:0] num_q;
	logic [IDX_W-1:0] off_q, cnt_q;
	logic [31:0] crc_q;
	logic [DVD_W-1:0] dvd_q;
	logic [15:0] tot_q;
	logic open_q;
	logic [7:0] byte_q;
	logic idx_ok_q;
	logic out_valid_q;
	logic emit;

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(dvd_q) * PROD_W'(RCP);

	always_comb begin
		if (ctrl.rd_cnt) begin
			raddr = cnt_q[AW-1:0];
		end else if (in_cmd == CMD_READ && in_idx < CHUNK_L) begin
			raddr = in_idx[AW-1:0];
		end else begin
			raddr = off_q[AW-1:0];
		end
		we = 1'b0;
		waddr = off_q[AW-1:0];
		wdata = rdata_q ^ byte_q;
		if (ctrl.clr) begin
			we = (cnt_q < CHUNK_L);
			waddr = cnt_q[AW-1:0];
			wdata = 8'd0;
		end else if (ctrl.apply) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ctrl.accept || ctrl.rd_cnt) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			byte_q <= in_byte;
			idx_ok_q <= (in_idx < CHUNK_L);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
			time_q <= '0;
			left_q <= '0;
			num_q <= '0;
			off_q <= '0;
			cnt_q <= '0;
			crc_q <= CRC_ONES;
			dvd_q <= '0;
			tot_q <= '0;
			open_q <= 1'b0;
		end else begin
			if (ctrl.start) begin
				seq_q <= in_seq;
				time_q <= in_time;
				left_q <= in_len;
				num_q <= '0;
				off_q <= '0;
				cnt_q <= '0;
				crc_q <= CRC_ONES;
				dvd_q <= DVD_W'(in_len) + ROUND_UP;
				open_q <= (in_len != '0);
			end
			if (ctrl.clr) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '0) begin
					tot_q <= 16'(prod >> RSH);
				end
			end
			if (ctrl.apply) begin
				crc_q <= crc_byte(crc_q, byte_q);
				off_q <= off_q + 1'b1;
				cnt_q <= off_q + 1'b1;
				left_q <= left_q - 1'b1;
			end
			if (ctrl.pad) begin
				crc_q <= crc_byte(crc_q, 8'd0);
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctrl.hdr) begin
				num_q <= num_q + 1'b1;
				off_q <= '0;
				cnt_q <= '0;
				crc_q <= CRC_ONES;
			end
			if (ctrl.pstep) begin
				crc_q <= crc_byte(crc_q, rdata_q);
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctrl.phdr) begin
				open_q <= 1'b0;
				crc_q <= CRC_ONES;
			end
		end
	end

	assign emit = ctrl.hdr | ctrl.phdr | ctrl.pbyte | ctrl.stray;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit | (out_valid_q & ~out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_seq <= seq_q;
			out_time <= time_q;
			out_kind <= KIND_STRAY;
			out_index <= '0;
			out_total <= '0;
			out_len <= '0;
			out_crc <= '0;
			out_pbyte <= '0;
			out_last <= 1'b1;
			if (ctrl.hdr) begin
				out_kind <= KIND_DATA;
				out_index <= num_q;
				out_total <= tot_q;
				out_len <= off_q;
				out_crc <= ~crc_q;
				out_last <= (left_q != '0);
			end else if (ctrl.phdr) begin
				out_kind <= KIND_PARITY;
				out_index <= PARITY_CHUNK;
				out_total <= tot_q;
				out_len <= CHUNK_L;
				out_crc <= ~crc_q;
			end else if (ctrl.pbyte) begin
				out_kind <= KIND_PBYTE;
				out_pbyte <= idx_ok_q ? rdata_q : 8'd0;
			end
		end
	end

	assign out_valid = out_valid_q;

	assign sts.open = open_q;
	assign sts.chunk_end = (left_q == LEN_W'(1)) || (off_q == CHUNK_LAST);
	assign sts.pad_done = (cnt_q == CHUNK_L);
	assign sts.frame_done = (left_q == '0);
	assign sts.par_last = (cnt_q == CHUNK_LAST);
	assign sts.clr_last = (cnt_q == CHUNK_LAST);
	assign sts.slot_free = ~out_valid_q | out_ready;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> sts.slot_free)
		else $error("result loaded while the output register is occupied");
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.apply |-> (off_q < CHUNK_L) && open_q)
		else $error("byte applied beyond the chunk or outside a frame");
	a_phdr_close: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.phdr |=> !open_q && (crc_q == CRC_ONES))
		else $error("frame not closed after the parity header");

endmodule

[rtl/frame_chunker_crc_parity_top.sv]
// ----------------------------------------------------------------------------
// frame_chunker_crc_parity_top
// Cuts frames into zero padded chunks, reports CRC-32 headers per chunk and
// a parity header per frame, and reads back parity bytes.
// A data byte is accepted in idle and then applied to the CRC and parity
// memory; a chunk end pads the missing bytes into the CRC and then loads the
// header, and a frame end adds a parity CRC pass that alternates a read and
// an update per parity byte before the parity header. A start request clears
// the parity memory before the next request is taken; parity reads and stray
// bytes give one result each. Requests are taken one at a time. After reset
// the parity memory is cleared before the first request is accepted.
// ----------------------------------------------------------------------------
module frame_chunker_crc_parity_top #(
	parameter int CHUNK_BYTES = 1100
) (
	input  logic clk,
	input  logic arst_n,
	fcc_in_if.sink in_ch,
	fcc_out_if.source out_ch
);
	import fcc_pkg::*;

	ctrl_t ctrl;
	sts_t sts;

	fcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_cmd   (in_ch.cmd),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.ctrl     (ctrl)
	);

	fcc_datapath #(
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sts       (sts),
		.in_cmd    (in_ch.cmd),
		.in_seq    (in_ch.frame_seq),
		.in_time   (in_ch.frame_timestamp),
		.in_len    (in_ch.frame_length),
		.in_byte   (in_ch.data_byte),
		.in_idx    (in_ch.parity_index),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_kind  (out_ch.kind),
		.out_seq   (out_ch.seq_out),
		.out_time  (out_ch.time_out),
		.out_index (out_ch.chunk_idx),
		.out_total (out_ch.chunk_total),
		.out_len   (out_ch.payload_length),
		.out_crc   (out_ch.chunk_crc),
		.out_pbyte (out_ch.parity_byte),
		.out_last  (out_ch.last)
	);

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives start, data, read and unused requests into the frame chunker and
// checks every result against a predictor of chunk headers, parity headers,
// parity read-back and stray byte errors.
// ----------------------------------------------------------------------------
module testbench;
	import fcc_pkg::*;

	localparam int CHUNK = 1100;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 3 * CHUNK + 100;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] seq;
		logic [63:0] ts;
		logic [23:0] len;
		logic [7:0]  dbyte;
		logic [10:0] idx;
	} request_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] seq;
		logic [63:0] ts;
		logic [15:0] index;
		logic [15:0] total;
		logic [10:0] plen;
		logic [31:0] crc;
		logic [7:0]  pbyte;
		logic        last;
	} header_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		header_t  want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fcc_in_if in_ch();
	fcc_out_if out_ch();

	frame_chunker_crc_parity_top #(.CHUNK_BYTES(CHUNK)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #2 clk = ~clk;

	header_t pending_headers[$];
	dir_row_t dir_tab[$];
	int mismatches = 0;
	int send_idle = 29;
	int recv_idle = 62;
	int stalled_cycles = 0;
	int sent_items = 0;

	logic [7:0]  par_mem[CHUNK];
	logic [31:0] run_crc;
	int          chunk_pos;
	logic [15:0] chunk_no;
	logic [15:0] chunk_cnt;
	logic [23:0] remaining;
	logic [63:0] cur_seq;
	logic [63:0] cur_ts;
	logic        in_frame;

	function automatic void queue_header(input header_t h);
		pending_headers.insert(pending_headers.size(), h);
	endfunction

	function automatic header_t take_header();
		header_t h;
		h = pending_headers[0];
		pending_headers.delete(0);
		return h;
	endfunction

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic void chunker_reset();
		foreach (par_mem[i]) par_mem[i] = 8'd0;
		run_crc = CRC_ONES;
		chunk_pos = 0;
		chunk_no = 16'd0;
		chunk_cnt = 16'd0;
		remaining = 24'd0;
		cur_seq = 64'd0;
		cur_ts = 64'd0;
		in_frame = 1'b0;
	endfunction

	function automatic void predict_headers(input request_t r);
		logic [31:0] pc;
		case (r.cmd)
			CMD_START: begin
				cur_seq = r.seq;
				cur_ts = r.ts;
				foreach (par_mem[i]) par_mem[i] = 8'd0;
				run_crc = CRC_ONES;
				chunk_pos = 0;
				chunk_no = 16'd0;
				remaining = r.len;
				chunk_cnt = 16'((int'(r.len) + CHUNK - 1) / CHUNK);
				in_frame = (r.len != 24'd0);
			end
			CMD_READ: begin
				queue_header({KIND_PBYTE, cur_seq, cur_ts, 16'd0, 16'd0, 11'd0,
					32'd0, (int'(r.idx) < CHUNK) ? par_mem[r.idx] : 8'd0, 1'b1});
			end
			CMD_DATA: begin
				if (!in_frame) begin
					queue_header({KIND_STRAY, cur_seq, cur_ts, 16'd0, 16'd0,
						11'd0, 32'd0, 8'd0, 1'b1});
				end else begin
					run_crc = crc_step(run_crc, r.dbyte);
					par_mem[chunk_pos] ^= r.dbyte;
					chunk_pos++;
					remaining = remaining - 24'd1;
					if (remaining == 24'd0 || chunk_pos >= CHUNK) begin
						for (int i = chunk_pos; i < CHUNK; i++) run_crc = crc_step(run_crc, 8'd0);
						queue_header({KIND_DATA, cur_seq, cur_ts, chunk_no, chunk_cnt,
							11'(chunk_pos), ~run_crc, 8'd0, remaining != 24'd0});
						chunk_no++;
						chunk_pos = 0;
						run_crc = CRC_ONES;
						if (remaining == 24'd0) begin
							pc = CRC_ONES;
							for (int i = 0; i < CHUNK; i++) pc = crc_step(pc, par_mem[i]);
							queue_header({KIND_PARITY, cur_seq, cur_ts, PARITY_CHUNK,
								chunk_cnt, 11'(CHUNK), ~pc, 8'd0, 1'b1});
							in_frame = 1'b0;
						end
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic send_request(input request_t r, input logic typed, input header_t want);
		int depth;
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= r.cmd;
		in_ch.frame_seq <= r.seq;
		in_ch.frame_timestamp <= r.ts;
		in_ch.frame_length <= r.len;
		in_ch.data_byte <= r.dbyte;
		in_ch.parity_index <= r.idx;
		do @(posedge clk); while (!in_ch.ready);
		depth = pending_headers.size();
		predict_headers(r);
		if (typed) begin
			while (pending_headers.size() > depth) void'(pending_headers.pop_back());
			queue_header(want);
		end
		if (r.cmd != CMD_UNUSED) sent_items++;
	endtask

	task automatic send_random(input logic [1:0] cmd, input logic [23:0] len, input logic [7:0] b);
		request_t r;
		r.cmd = cmd;
		r.seq = {$urandom, $urandom};
		r.ts = {$urandom, $urandom};
		r.len = len;
		r.dbyte = b;
		r.idx = 11'($urandom_range(2047));
		send_request(r, 1'b0, '0);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_headers.size() != 0) @(posedge clk);
	endtask

	task automatic random_burst();
		int n;
		int sel;
		sel = $urandom_range(99);
		if (sel < 78) begin
			n = (sel < 8) ? $urandom_range(60, 120) : $urandom_range(1, 24);
			send_random(CMD_START, 24'(n), 8'($urandom));
			while (n > 0) begin
				sel = $urandom_range(99);
				if (sel < 8) send_random(CMD_READ, 24'($urandom), 8'($urandom));
				else if (sel < 11) send_random(CMD_UNUSED, 24'($urandom), 8'($urandom));
				else begin
					send_random(CMD_DATA, 24'($urandom), 8'($urandom));
					n--;
				end
			end
		end else if (sel < 84) begin
			send_random(CMD_START, 24'($urandom), 8'($urandom));
			repeat ($urandom_range(0, 6)) send_random(CMD_DATA, 24'($urandom), 8'($urandom));
		end else if (sel < 88) begin
			send_random(CMD_START, 24'd0, 8'($urandom));
		end else if (sel < 93) begin
			send_random(CMD_DATA, 24'($urandom), 8'($urandom));
		end else if (sel < 98) begin
			send_random(CMD_READ, 24'($urandom), 8'($urandom));
		end else begin
			send_random(CMD_UNUSED, 24'($urandom), 8'($urandom));
		end
	endtask

	function automatic void add_row(input logic [1:0] cmd, input logic [63:0] seq,
		input logic [63:0] ts, input logic [23:0] len, input logic [7:0] b,
		input logic [10:0] idx, input logic typed, input logic [1:0] kind);
		dir_row_t row;
		row.req = {cmd, seq, ts, len, b, idx};
		row.typed = typed;
		row.want = {kind, 64'd0, 64'd0, 16'd0, 16'd0, 11'd0, 32'd0, 8'd0, 1'b1};
		dir_tab.insert(dir_tab.size(), row);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				stalled_cycles <= 0;
			end else if (stalled_cycles >= STALL_LIMIT) begin
				$display("frame_chunker_crc_parity_top verification failed");
				$finish;
			end else begin
				stalled_cycles <= stalled_cycles + 1;
			end
		end
	end

	always @(posedge clk) begin
		header_t got;
		header_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.kind, out_ch.seq_out, out_ch.time_out, out_ch.chunk_idx,
					out_ch.chunk_total, out_ch.payload_length, out_ch.chunk_crc,
					out_ch.parity_byte, out_ch.last};
				if (pending_headers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("Unexpected result: %p", got);
				end else begin
					want = take_header();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
					end
				end
			end
		end
		out_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_UNUSED;
		in_ch.frame_seq = 64'd0;
		in_ch.frame_timestamp = 64'd0;
		in_ch.frame_length = 24'd0;
		in_ch.data_byte = 8'd0;
		in_ch.parity_index = 11'd0;
		chunker_reset();

		add_row(CMD_READ, 64'd0, 64'd0, 24'd0, 8'h00, 11'd0, 1'b1, KIND_PBYTE);
		add_row(CMD_READ, 64'd0, 64'd0, 24'd0, 8'h00, 11'd2047, 1'b1, KIND_PBYTE);
		add_row(CMD_DATA, 64'd0, 64'd0, 24'd0, 8'hFF, 11'd0, 1'b1, KIND_STRAY);
		add_row(CMD_UNUSED, 64'd0, 64'd0, 24'd0, 8'h00, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_START, '1, 64'h8000_0000_0000_0000, 24'd1, 8'h00, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_DATA, 64'd0, 64'd0, 24'd0, 8'hFF, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_START, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 24'd0, 8'h00, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_DATA, 64'd0, 64'd0, 24'd0, 8'h00, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_START, 64'd1, '1, 24'hFFFFFF, 8'h00, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_DATA, 64'd0, 64'd0, 24'd0, 8'hA5, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_READ, 64'd0, 64'd0, 24'd0, 8'h00, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_START, 64'd2, 64'd5, 24'd3, 8'h00, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_DATA, 64'd0, 64'd0, 24'd0, 8'h00, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_DATA, 64'd0, 64'd0, 24'd0, 8'hFF, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_DATA, 64'd0, 64'd0, 24'd0, 8'h5A, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_READ, 64'd0, 64'd0, 24'd0, 8'h00, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_READ, 64'd0, 64'd0, 24'd0, 8'h00, 11'd2, 1'b0, KIND_DATA);
		add_row(CMD_READ, 64'd0, 64'd0, 24'd0, 8'h00, 11'd1099, 1'b0, KIND_DATA);
		add_row(CMD_READ, 64'd0, 64'd0, 24'd0, 8'h00, 11'd1100, 1'b0, KIND_DATA);
		add_row(CMD_START, 64'd3, 64'd7, 24'd4, 8'h00, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_DATA, 64'd0, 64'd0, 24'd0, 8'h11, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_DATA, 64'd0, 64'd0, 24'd0, 8'h22, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_READ, 64'd0, 64'd0, 24'd0, 8'h00, 11'd1, 1'b0, KIND_DATA);
		add_row(CMD_DATA, 64'd0, 64'd0, 24'd0, 8'h33, 11'd0, 1'b0, KIND_DATA);
		add_row(CMD_DATA, 64'd0, 64'd0, 24'd0, 8'h44, 11'd0, 1'b0, KIND_DATA);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
		drain_results();

		while (sent_items < 100) random_burst();
		drain_results();
		send_idle = 62;
		recv_idle = 29;
		while (sent_items < 200) random_burst();
		drain_results();
		send_idle = 0;
		recv_idle = 0;
		// One frame that fills a whole chunk and spills a single byte into a second one.
		send_random(CMD_START, 24'(CHUNK + 1), 8'd0);
		repeat (CHUNK + 1) send_random(CMD_DATA, 24'($urandom), 8'($urandom));
		while (sent_items < 1300) random_burst();
		drain_results();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_headers.size() == 0) begin
			$display("frame_chunker_crc_parity_top verification clean");
		end else begin
			$display("frame_chunker_crc_parity_top verification failed");
		end
		$finish;
	end

endmodule
